// ===== hw/rtl/b64d_pkg.sv =====
// Shared types, constants and the character map for the base64 decoder.
package b64d_pkg;

    // Pad character '='
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Group position codes (values already held)
    localparam logic [1:0] POS_EMPTY = 2'd0;
    localparam logic [1:0] POS_ONE   = 2'd1;
    localparam logic [1:0] POS_TWO   = 2'd2;
    localparam logic [1:0] POS_THREE = 2'd3;

    // Input word: one encoded character
    typedef struct packed {
        logic [7:0] in_char;
        logic       last_char;
    } in_word_t;

    // Output word: one decoded byte
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       message_end;
    } out_word_t;

    // Decoded group handed to the output buffer; first byte in the top bits
    typedef struct packed {
        logic [23:0] bytes;
        logic [1:0]  count;
        logic        last;
    } group_t;

    // Permissive character map to a 6-bit value
    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [5:0] v;
        v = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B || c == 8'h2D || c == 8'h2E) begin
            v = 6'd62;
        end else if (c == 8'h2F || c == 8'h2C || c == 8'h5F) begin
            v = 6'd63;
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/b64d_in_reg.sv =====
// Input register stage of the base64 decoder.
module b64d_in_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  b64d_pkg::in_word_t s_data,
    input  logic               advance,
    output logic               held_valid,
    output b64d_pkg::in_word_t held_data
);
    import b64d_pkg::*;

    logic     valid_reg;
    in_word_t data_reg;

    // Room when empty or when the held word moves on this cycle
    assign s_ready    = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_data  = data_reg;

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

// ===== hw/rtl/b64d_group.sv =====
// Group assembly: maps a character, tracks group state and forms the output bytes.
module b64d_group (
    input  logic               aclk,
    input  logic               aresetn,
    input  b64d_pkg::in_word_t in_data,
    input  logic               advance,
    output b64d_pkg::group_t   grp
);
    import b64d_pkg::*;

    logic [17:0] held_reg;
    logic [17:0] held_next;
    logic [1:0]  pos_reg;
    logic [1:0]  pos_next;
    logic        pad3_reg;
    logic        pad3_next;

    logic [5:0]  v;
    logic        is_pad;
    logic        last;

    assign v      = sextet_of(in_data.in_char);
    assign is_pad = (in_data.in_char == PAD_CHAR);
    assign last   = in_data.last_char;

    // Output bytes and count for this character
    always_comb begin
        grp.bytes = 24'd0;
        grp.count = 2'd0;
        grp.last  = last;
        unique case (pos_reg)
            POS_THREE: begin
                grp.bytes = {held_reg, v};
                if (!last || !is_pad) begin
                    grp.count = 2'd3;
                end else if (!pad3_reg) begin
                    grp.count = 2'd2;
                end else begin
                    grp.count = 2'd1;
                end
            end
            POS_TWO: begin
                if (last) begin
                    grp.bytes = {held_reg[11:0], v, 6'd0};
                    grp.count = 2'd2;
                end
            end
            POS_ONE: begin
                if (last) begin
                    grp.bytes = {held_reg[5:0], v, 12'd0};
                    grp.count = 2'd1;
                end
            end
            default: begin
                grp.count = 2'd0;
            end
        endcase
    end

    // Next group state: clear at group end or message end
    always_comb begin
        held_next = held_reg;
        pos_next  = pos_reg;
        pad3_next = pad3_reg;
        if (pos_reg == POS_THREE || last) begin
            held_next = 18'd0;
            pos_next  = POS_EMPTY;
            pad3_next = 1'b0;
        end else begin
            if (pos_reg == POS_TWO) begin
                pad3_next = is_pad;
            end
            held_next = {held_reg[11:0], v};
            pos_next  = pos_reg + 2'd1;
        end
    end

    // Group state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= 18'd0;
            pos_reg  <= POS_EMPTY;
            pad3_reg <= 1'b0;
        end else if (advance) begin
            held_reg <= held_next;
            pos_reg  <= pos_next;
            pad3_reg <= pad3_next;
        end
    end

endmodule

// ===== hw/rtl/b64d_out_buf.sv =====
// Result register: holds up to three decoded bytes and sends them one per word.
module b64d_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  b64d_pkg::group_t    grp,
    output logic                free,
    output logic                m_valid,
    input  logic                m_ready,
    output b64d_pkg::out_word_t m_data
);
    import b64d_pkg::*;

    logic [23:0] bytes_reg;
    logic [1:0]  cnt_reg;
    logic        last_reg;

    assign m_valid            = (cnt_reg != 2'd0);
    assign m_data.out_byte    = bytes_reg[23:16];
    assign m_data.run_end     = (cnt_reg == 2'd1);
    assign m_data.message_end = (cnt_reg == 2'd1) && last_reg;

    // Empty now, or empty after the word being taken
    assign free = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);

    // Remaining byte count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= grp.count;
        end else if (m_valid && m_ready) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Byte shift register and message-end flag
    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg <= grp.bytes;
            last_reg  <= grp.last;
        end else if (m_valid && m_ready) begin
            bytes_reg <= {bytes_reg[15:0], 8'd0};
        end
    end

endmodule

// ===== hw/rtl/base64_decoder_core.sv =====
// Top level of the streaming base64 decoder.
//
// Streaming base64 decoder: one character per input word, with a flag on the
// character that ends the message. Characters are mapped permissively ('+',
// '-', '.' give 62; '/', ',', '_' give 63; anything else outside the alphabet,
// '=' included, gives 0). A full group of four yields three bytes; the final
// group yields 3, 2 or 1 bytes depending on length and trailing '=' padding,
// and a one-character tail yields none. Each input word passes through an
// input register, then the group logic, into a three-byte result register
// that sends one byte per output word. A character is accepted every cycle;
// only the fourth character of a group, or a last character with output,
// waits for the result register to drain, so a steady stream of full groups
// runs at one character per cycle while the output is ready. A character that
// yields bytes passes through the input register and then the result register.
module base64_decoder_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  b64d_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output b64d_pkg::out_word_t m_data
);
    import b64d_pkg::*;

    logic     held_valid;
    in_word_t held_data;
    group_t   grp;
    logic     free;
    logic     advance;
    logic     load;

    // A held character moves on if it makes no bytes or the buffer has room
    assign advance = held_valid && ((grp.count == 2'd0) || free);
    assign load    = advance && (grp.count != 2'd0);

    b64d_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (advance),
        .held_valid (held_valid),
        .held_data  (held_data)
    );

    b64d_group u_group (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_data (held_data),
        .advance (advance),
        .grp     (grp)
    );

    b64d_out_buf u_out_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .grp     (grp),
        .free    (free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
